### src/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants for the first-fit bitmap block allocator: field widths
// and default geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

   // Fixed field widths of the request and response words
   localparam int COUNT_W = 7;
   localparam int INDEX_W = 12;

   // Default geometry
   localparam int DEF_NUM_BLOCKS  = 4096;
   localparam int DEF_WORD_BITS   = 32;
   localparam int DEF_MAX_REQUEST = 64;

   // Response status codes
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REFUSE = 1'b1;

endpackage : bba_pkg

`default_nettype wire

### src/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit data block allocator over a used-block bitmap held in a
// synchronous memory.
//
//   channel | dir | handshake            | word
//   --------+-----+----------------------+-------------------------------------
//   req     | in  | req_valid/req_stall  | request_count
//   rsp     | out | rsp_valid/rsp_stall  | block_index, last, status
//
// Sequence: accept, then a read and a check for each bitmap word visited and
// a claim for each block claimed; the memory's registered read data sets the
// per-word cost. A refusal answers next cycle. Reset: control state clears and
// the free count returns to NUM_BLOCKS; a high-water mark makes never-written
// bitmap words read as all free, so there is no clearing pass. Stalls: a
// stalled response holds claims; a request waits for idle and an empty slot.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_block_allocator
   import bba_pkg::*;
#(
   parameter int NUM_BLOCKS  = DEF_NUM_BLOCKS,
   parameter int WORD_BITS   = DEF_WORD_BITS,
   parameter int MAX_REQUEST = DEF_MAX_REQUEST
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [COUNT_W-1:0] req_request_count,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic      [INDEX_W-1:0] rsp_block_index,
   output logic                    rsp_last,
   output logic                    rsp_status
);

   localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

   logic                 mem_wr_en;
   logic [ADDR_W-1:0]    mem_wr_addr;
   logic [WORD_BITS-1:0] mem_wr_data;
   logic                 mem_rd_en;
   logic [ADDR_W-1:0]    mem_rd_addr;
   logic [WORD_BITS-1:0] mem_rd_data;

   // Bitmap storage
   bba_map_mem #(
      .DEPTH  (MAP_WORDS),
      .WIDTH  (WORD_BITS),
      .ADDR_W (ADDR_W)
   ) u_map_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Scan sequencer and response register
   bba_ctrl #(
      .NUM_BLOCKS  (NUM_BLOCKS),
      .WORD_BITS   (WORD_BITS),
      .MAX_REQUEST (MAX_REQUEST),
      .MAP_WORDS   (MAP_WORDS),
      .ADDR_W      (ADDR_W)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_request_count (req_request_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_block_index   (rsp_block_index),
      .rsp_last          (rsp_last),
      .rsp_status        (rsp_status),
      .mem_wr_en         (mem_wr_en),
      .mem_wr_addr       (mem_wr_addr),
      .mem_wr_data       (mem_wr_data),
      .mem_rd_en         (mem_rd_en),
      .mem_rd_addr       (mem_rd_addr),
      .mem_rd_data       (mem_rd_data)
   );

   // A refusal is a single word: last set, index zero
   a_refuse_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_REFUSE)
         |-> rsp_last && (rsp_block_index == '0))
      else $error("refused response not a single zero word");

   // No new request while a response word is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while response pending");

   // After a refusal is accepted downstream, nothing else is in flight
   a_refuse_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && (rsp_status == STATUS_REFUSE) |=> !rsp_valid)
      else $error("extra response after refusal");

endmodule : bitmap_block_allocator

`default_nettype wire

### src/bba_map_mem.sv
// ----------------------------------------------------------------------------
// bba_map_mem
// Used-block bitmap storage: one write port, one read port, registered
// read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_map_mem
   import bba_pkg::*;
#(
   parameter int DEPTH  = DEF_NUM_BLOCKS / DEF_WORD_BITS,
   parameter int WIDTH  = DEF_WORD_BITS,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] map_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= map_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : bba_map_mem

`default_nettype wire

### src/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Request sequencer: checks a nonzero request within MAX_REQUEST against the
// free count, walks the bitmap word by word through the memory, claims free
// bits MSB first, and drives the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ctrl
   import bba_pkg::*;
#(
   parameter int NUM_BLOCKS  = DEF_NUM_BLOCKS,
   parameter int WORD_BITS   = DEF_WORD_BITS,
   parameter int MAX_REQUEST = DEF_MAX_REQUEST,
   parameter int MAP_WORDS   = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS,
   parameter int ADDR_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [COUNT_W-1:0]   req_request_count,
   // response channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic      [INDEX_W-1:0]   rsp_block_index,
   output logic                      rsp_last,
   output logic                      rsp_status,
   // bitmap memory
   output logic                      mem_wr_en,
   output logic      [ADDR_W-1:0]    mem_wr_addr,
   output logic      [WORD_BITS-1:0] mem_wr_data,
   output logic                      mem_rd_en,
   output logic      [ADDR_W-1:0]    mem_rd_addr,
   input  wire logic [WORD_BITS-1:0] mem_rd_data
);

   localparam int HW_W   = $clog2(MAP_WORDS + 1);
   localparam int BLK_W  = $clog2(NUM_BLOCKS);
   localparam int FREE_W = $clog2(NUM_BLOCKS + 1);
   localparam int POS_W  = $clog2(WORD_BITS);
   localparam int CMP_W  = (FREE_W > COUNT_W) ? FREE_W : COUNT_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [BLK_W-1:0]     base_ff, base_in;
   logic [WORD_BITS-1:0] word_ff, word_in;
   logic [COUNT_W-1:0]   remain_ff, remain_in;
   logic [FREE_W-1:0]    free_ff, free_in;
   logic [HW_W-1:0]      hw_ff, hw_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_status_ff, rsp_status_in;

   logic                 req_take;
   logic                 req_ok;
   logic                 out_free;
   logic                 hit;
   logic [POS_W-1:0]     hit_bit;
   logic [POS_W-1:0]     hit_off;
   logic [WORD_BITS-1:0] word_set;
   logic [BLK_W-1:0]     blk_idx;
   logic [BLK_W+INDEX_W-1:0] blk_ext;
   logic [CMP_W-1:0]     want_cmp;
   logic [CMP_W-1:0]     free_cmp;

   // Handshake: one request at a time, taken only with an empty response slot
   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Admission check
   assign want_cmp = CMP_W'(req_request_count);
   assign free_cmp = CMP_W'(free_ff);
   assign req_ok   = (req_request_count != '0)
                     && (req_request_count <= COUNT_W'(MAX_REQUEST))
                     && (free_cmp >= want_cmp);

   // First free bit, MSB side = lowest block
   always_comb begin
      hit     = 1'b0;
      hit_bit = '0;
      hit_off = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (!word_ff[i]) begin
            hit     = 1'b1;
            hit_bit = POS_W'(i);
            hit_off = POS_W'(WORD_BITS - 1 - i);
         end
      end
   end

   assign word_set = word_ff | (WORD_BITS'(1) << hit_bit);
   assign blk_idx  = base_ff + BLK_W'(hit_off);
   assign blk_ext  = {{INDEX_W{1'b0}}, blk_idx};

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      base_in       = base_ff;
      word_in       = word_ff;
      remain_in     = remain_ff;
      free_in       = free_ff;
      hw_in         = hw_ff;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = addr_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_index_in  = rsp_index_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_ok) begin
                  addr_in     = '0;
                  base_in     = '0;
                  remain_in   = req_request_count;
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = '0;
                  state_in    = ST_READ;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_index_in  = '0;
                  rsp_last_in   = 1'b1;
                  rsp_status_in = STATUS_REFUSE;
               end
            end
         end
         ST_READ: begin
            // Words past the high-water mark were never written: all free
            word_in  = (HW_W'(addr_ff) < hw_ff) ? mem_rd_data : '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (!hit) begin
               // Word full: write back, fetch the next one
               mem_wr_en   = 1'b1;
               addr_in     = addr_ff + ADDR_W'(1);
               base_in     = base_ff + BLK_W'(WORD_BITS);
               mem_rd_en   = 1'b1;
               mem_rd_addr = addr_ff + ADDR_W'(1);
               state_in    = ST_READ;
            end else if (out_free) begin
               // Claim one block
               word_in       = word_set;
               remain_in     = remain_ff - COUNT_W'(1);
               free_in       = free_ff - FREE_W'(1);
               rsp_valid_in  = 1'b1;
               rsp_index_in  = blk_ext[INDEX_W-1:0];
               rsp_last_in   = (remain_ff == COUNT_W'(1));
               rsp_status_in = STATUS_OK;
               if (remain_ff == COUNT_W'(1)) begin
                  mem_wr_en = 1'b1;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Track highest word ever written
      if (mem_wr_en && (HW_W'(addr_ff) >= hw_ff)) begin
         hw_in = HW_W'(addr_ff) + HW_W'(1);
      end
   end

   assign mem_wr_addr = addr_ff;
   assign mem_wr_data = word_in;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_ff      <= FREE_W'(NUM_BLOCKS);
         hw_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_ff      <= free_in;
         hw_ff        <= hw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      base_ff       <= base_in;
      word_ff       <= word_in;
      remain_ff     <= remain_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_block_index = rsp_index_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_status      = rsp_status_ff;

endmodule : bba_ctrl

`default_nettype wire
